// ===== src/fpba_pkg.sv =====
// Shared types and constants for the fit-policy block allocator.
// Used by the front end, back end and top level of the block and by the port checker; no dependencies.
`default_nettype none

package fpba_pkg;

    // Default sizes of the capacity table
    localparam int NUM_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    // Port widths fixed by the field layout
    localparam int DATA_W      = 24;   // index(4) + size(16), padded to bytes
    localparam int IN_USER_W   = 1;
    localparam int OUT_USER_W  = 2;
    localparam int IDX_W       = 4;
    localparam int FIELD_SIZE_W = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;

    // Command queue between front and back
    localparam int Q_DEPTH      = 2;
    localparam int MAX_INFLIGHT = Q_DEPTH + 2;   // queue + back + output register

    // Operation codes on s_tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd1;

    // Selection rules; the unused code behaves as first fit
    localparam logic [1:0] POLICY_FIRST = 2'd0;
    localparam logic [1:0] POLICY_BEST  = 2'd1;
    localparam logic [1:0] POLICY_WORST = 2'd2;

    // Result status codes on m_tuser
    localparam logic [OUT_USER_W-1:0] STATUS_LOADED = 2'd0;
    localparam logic [OUT_USER_W-1:0] STATUS_ALLOC  = 2'd1;
    localparam logic [OUT_USER_W-1:0] STATUS_NOFIT  = 2'd2;

    // Reset value of block_count
    localparam logic [CFG_DATA_W-1:0] BLOCK_COUNT_RST = 5'd16;

    // Classified command kinds
    typedef enum logic [1:0] {
        CMD_LOAD      = 2'd0,
        CMD_LOAD_SKIP = 2'd1,
        CMD_ALLOC     = 2'd2
    } cmd_kind_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_DRAIN = 2'd2,
        ST_DONE  = 2'd3
    } bk_state_t;

    // Configuration seen by the back end
    typedef struct packed {
        logic [1:0]            policy;
        logic [CFG_DATA_W-1:0] block_count;
    } cfg_t;

endpackage

`default_nettype wire

// ===== src/fpba_front.sv =====
// Front end: configuration registers, input transfer and command classification.
// Depends on fpba_pkg; feeds fpba_queue.
`default_nettype none

module fpba_front #(
    parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF,
    localparam int CMD_W     = 2 + fpba_pkg::IDX_W + SIZE_BITS
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [fpba_pkg::DATA_W-1:0]         s_tdata,  // block_index[3:0], size_value[19:4]
    input  wire  [fpba_pkg::IN_USER_W-1:0]      s_tuser,  // operation[0]
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [fpba_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [fpba_pkg::CFG_DATA_W-1:0]     cfg_data,
    output fpba_pkg::cfg_t                      cfg,
    output logic                                q_push,
    input  wire                                 q_ready,
    output logic [CMD_W-1:0]                    q_data
);

    logic [1:0]                        policy_reg;
    logic [fpba_pkg::CFG_DATA_W-1:0]   count_reg;
    logic [fpba_pkg::IDX_W-1:0]        idx;
    logic [31:0]                       size_wide;
    logic [SIZE_BITS-1:0]              size_red;
    fpba_pkg::cmd_kind_t               kind;

    // Configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= fpba_pkg::POLICY_FIRST;
            count_reg  <= fpba_pkg::BLOCK_COUNT_RST;
        end else if (cfg_valid) begin
            if (cfg_index == fpba_pkg::REG_FIT_POLICY) begin
                policy_reg <= cfg_data[1:0];
            end else if (cfg_index == fpba_pkg::REG_BLOCK_COUNT) begin
                count_reg <= cfg_data;
            end
        end
    end

    assign cfg.policy      = policy_reg;
    assign cfg.block_count = count_reg;

    // Field unpacking and size reduction to the table width
    assign idx       = s_tdata[fpba_pkg::IDX_W-1:0];
    assign size_wide = 32'(s_tdata[fpba_pkg::IDX_W +: fpba_pkg::FIELD_SIZE_W]);
    assign size_red  = size_wide[SIZE_BITS-1:0];

    // Classify: allocate, load in range, or load beyond the table
    always_comb begin
        if (s_tuser[0] == fpba_pkg::OP_ALLOC) begin
            kind = fpba_pkg::CMD_ALLOC;
        end else if (32'(idx) < NUM_BLOCKS) begin
            kind = fpba_pkg::CMD_LOAD;
        end else begin
            kind = fpba_pkg::CMD_LOAD_SKIP;
        end
    end

    assign s_tready = q_ready;
    assign q_push   = s_tvalid;
    assign q_data   = {size_red, idx, kind};

endmodule

`default_nettype wire

// ===== src/fpba_queue.sv =====
// Short command FIFO that decouples the front end from the back end.
// Depends on nothing but its parameters.
`default_nettype none

module fpba_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          in_valid,
    output logic         in_ready,
    input  wire  [W-1:0] in_data,
    output logic         out_valid,
    input  wire          out_pop,
    output logic [W-1:0] out_data
);

    logic [W-1:0]  slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          push;
    logic          pop;

    assign in_ready  = (cnt_reg != CW'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/fpba_back.sv =====
// Back end: capacity table, sequential fit search and result register.
// Depends on fpba_pkg; takes commands from fpba_queue.
`default_nettype none

module fpba_back #(
    parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF,
    localparam int CMD_W     = 2 + fpba_pkg::IDX_W + SIZE_BITS,
    localparam int AW        = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1,
    localparam int LW        = $clog2(NUM_BLOCKS + 1)
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  fpba_pkg::cfg_t                       cfg,
    input  wire                                  q_valid,
    output logic                                 q_pop,
    input  wire  [CMD_W-1:0]                     q_data,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [fpba_pkg::DATA_W-1:0]          m_tdata,  // chosen_block[3:0], remaining_size[19:4]
    output logic [fpba_pkg::OUT_USER_W-1:0]      m_tuser   // status[1:0]
);

    // Capacity table, no reset: entries are defined once loaded
    logic [SIZE_BITS-1:0] cap_mem [NUM_BLOCKS];

    fpba_pkg::bk_state_t  state_reg, state_next;

    fpba_pkg::cmd_kind_t  cmd_kind;
    logic [fpba_pkg::IDX_W-1:0] cmd_idx;
    logic [SIZE_BITS-1:0] cmd_size;
    logic [31:0]          limit_now;

    logic [AW-1:0]        addr_reg;
    logic [LW-1:0]        limit_reg;
    logic [SIZE_BITS-1:0] req_reg;
    logic                 rd_valid_reg;
    logic [AW-1:0]        rd_idx_reg;
    logic [SIZE_BITS-1:0] rd_data_reg;
    logic                 found_reg;
    logic [AW-1:0]        best_idx_reg;
    logic [SIZE_BITS-1:0] best_val_reg;
    logic                 scan_last;
    logic                 take;
    logic [SIZE_BITS-1:0] diff;

    logic                 out_free;
    logic                 scan_start;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [SIZE_BITS-1:0] mem_wdata;
    logic                 emit;
    logic [fpba_pkg::OUT_USER_W-1:0] emit_status;
    logic [fpba_pkg::IDX_W-1:0]      emit_block;
    logic [fpba_pkg::FIELD_SIZE_W-1:0] emit_rem;

    logic                 m_valid_reg;
    logic [fpba_pkg::OUT_USER_W-1:0] m_status_reg;
    logic [fpba_pkg::IDX_W-1:0]      m_block_reg;
    logic [fpba_pkg::FIELD_SIZE_W-1:0] m_rem_reg;

    // Command fields at the queue head
    assign cmd_kind = fpba_pkg::cmd_kind_t'(q_data[1:0]);
    assign cmd_idx  = q_data[2 +: fpba_pkg::IDX_W];
    assign cmd_size = q_data[CMD_W-1 -: SIZE_BITS];

    // Entries searched, saturated to the table size
    assign limit_now = (32'(cfg.block_count) > NUM_BLOCKS) ? 32'(NUM_BLOCKS)
                                                           : 32'(cfg.block_count);

    assign out_free  = !m_valid_reg || m_tready;
    assign scan_last = (32'(addr_reg) + 32'd1 == 32'(limit_reg));
    assign diff      = best_val_reg - req_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fpba_pkg::ST_IDLE: begin
                if (q_valid && cmd_kind == fpba_pkg::CMD_ALLOC) begin
                    state_next = (limit_now == 32'd0) ? fpba_pkg::ST_DONE
                                                      : fpba_pkg::ST_SCAN;
                end
            end
            fpba_pkg::ST_SCAN: begin
                if (scan_last) begin
                    state_next = fpba_pkg::ST_DRAIN;
                end
            end
            fpba_pkg::ST_DRAIN: state_next = fpba_pkg::ST_DONE;
            fpba_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = fpba_pkg::ST_IDLE;
                end
            end
            default: state_next = fpba_pkg::ST_IDLE;
        endcase
    end

    // State outputs: queue pop, table write, result emit
    always_comb begin
        q_pop       = 1'b0;
        scan_start  = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = AW'(cmd_idx);
        mem_wdata   = cmd_size;
        emit        = 1'b0;
        emit_status = fpba_pkg::STATUS_LOADED;
        emit_block  = cmd_idx;
        emit_rem    = '0;
        unique case (state_reg)
            fpba_pkg::ST_IDLE: begin
                if (q_valid) begin
                    unique case (cmd_kind)
                        fpba_pkg::CMD_LOAD: begin
                            if (out_free) begin
                                q_pop    = 1'b1;
                                mem_we   = 1'b1;
                                emit     = 1'b1;
                                emit_rem = fpba_pkg::FIELD_SIZE_W'(cmd_size);
                            end
                        end
                        fpba_pkg::CMD_LOAD_SKIP: begin
                            if (out_free) begin
                                q_pop = 1'b1;
                                emit  = 1'b1;
                            end
                        end
                        fpba_pkg::CMD_ALLOC: begin
                            q_pop      = 1'b1;
                            scan_start = 1'b1;
                        end
                        default: q_pop = 1'b1;
                    endcase
                end
            end
            fpba_pkg::ST_SCAN, fpba_pkg::ST_DRAIN: begin
            end
            fpba_pkg::ST_DONE: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (found_reg) begin
                        emit_status = fpba_pkg::STATUS_ALLOC;
                        emit_block  = fpba_pkg::IDX_W'(best_idx_reg);
                        emit_rem    = fpba_pkg::FIELD_SIZE_W'(diff);
                        mem_we      = 1'b1;
                        mem_waddr   = best_idx_reg;
                        mem_wdata   = diff;
                    end else begin
                        emit_status = fpba_pkg::STATUS_NOFIT;
                        emit_block  = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fpba_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Table port: one write, one registered read at the scan address
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cap_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= cap_mem[addr_reg];
        rd_idx_reg  <= addr_reg;
    end

    // Scan address and request
    always_ff @(posedge aclk) begin
        if (scan_start) begin
            addr_reg  <= '0;
            limit_reg <= LW'(limit_now);
            req_reg   <= cmd_size;
        end else if (state_reg == fpba_pkg::ST_SCAN) begin
            addr_reg <= addr_reg + 1'b1;
        end
    end

    // Candidate compare: fits, and better than the current pick under the policy
    assign take = !found_reg
               || (cfg.policy == fpba_pkg::POLICY_BEST  && rd_data_reg < best_val_reg)
               || (cfg.policy == fpba_pkg::POLICY_WORST && rd_data_reg > best_val_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
        end else begin
            rd_valid_reg <= (state_reg == fpba_pkg::ST_SCAN);
            if (scan_start) begin
                found_reg <= 1'b0;
            end else if (rd_valid_reg && rd_data_reg >= req_reg && take) begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!scan_start && rd_valid_reg && rd_data_reg >= req_reg && take) begin
            best_idx_reg <= rd_idx_reg;
            best_val_reg <= rd_data_reg;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_status_reg <= emit_status;
            m_block_reg  <= emit_block;
            m_rem_reg    <= emit_rem;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(fpba_pkg::DATA_W - fpba_pkg::FIELD_SIZE_W - fpba_pkg::IDX_W){1'b0}},
                       m_rem_reg, m_block_reg};

endmodule

`default_nettype wire

// ===== src/fit_policy_block_allocator.sv =====
// Sequence: a load goes from the queue head into the result register; an allocate goes from
// the queue head through ST_SCAN over N entries (N = searched entries, at most NUM_BLOCKS),
// ST_DRAIN and ST_DONE to the result register, skipping ST_SCAN and ST_DRAIN when N is 0.
// One item is in the back end at a time; the scan reads the capacity table one entry per cycle.
// A 2-entry queue keeps taking items meanwhile. Reset (aresetn low, synchronous) clears
// control state, sets fit_policy to first fit and block_count to 16; table not cleared.
`default_nettype none

module fit_policy_block_allocator #(
    parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [fpba_pkg::DATA_W-1:0]         s_tdata,  // block_index[3:0], size_value[19:4]
    input  wire  [fpba_pkg::IN_USER_W-1:0]      s_tuser,  // operation[0]
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [fpba_pkg::DATA_W-1:0]         m_tdata,  // chosen_block[3:0], remaining_size[19:4]
    output logic [fpba_pkg::OUT_USER_W-1:0]     m_tuser,  // status[1:0]
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [fpba_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [fpba_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CMD_W = 2 + fpba_pkg::IDX_W + SIZE_BITS;

    fpba_pkg::cfg_t     cfg;
    logic               push;
    logic               push_ready;
    logic [CMD_W-1:0]   push_data;
    logic               head_valid;
    logic               head_pop;
    logic [CMD_W-1:0]   head_data;

    // Front end: config and classification
    fpba_front #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .q_push    (push),
        .q_ready   (push_ready),
        .q_data    (push_data)
    );

    // Command queue
    fpba_queue #(
        .W     (CMD_W),
        .DEPTH (fpba_pkg::Q_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push),
        .in_ready  (push_ready),
        .in_data   (push_data),
        .out_valid (head_valid),
        .out_pop   (head_pop),
        .out_data  (head_data)
    );

    // Back end: table, search, results
    fpba_back #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (head_valid),
        .q_pop    (head_pop),
        .q_data   (head_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ===== src/fpba_checker.sv =====
// Port-level checker for the fit-policy block allocator, bound to the top level.
// Depends on fpba_pkg and fit_policy_block_allocator.
`default_nettype none

module fpba_checker (
    input wire                                 aclk,
    input wire                                 aresetn,
    input wire                                 s_tvalid,
    input wire                                 s_tready,
    input wire                                 m_tvalid,
    input wire                                 m_tready,
    input wire [fpba_pkg::DATA_W-1:0]          m_tdata,
    input wire [fpba_pkg::OUT_USER_W-1:0]      m_tuser
);

    logic       in_xfer;
    logic       out_xfer;
    logic [3:0] pend_reg;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    // Items taken but not yet answered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_reg + 4'(in_xfer) - 4'(out_xfer);
        end
    end

    // No result without an item waiting for it
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pend_reg != 4'd0)
        else $error("result shown with no item outstanding");

    // The queue, back end and output register bound the items in flight
    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= 4'(fpba_pkg::MAX_INFLIGHT))
        else $error("more items in flight than the block can hold");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A failed request reports block 0 with nothing left
    a_nofit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == fpba_pkg::STATUS_NOFIT |-> m_tdata == '0)
        else $error("no-fit result carries data");

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (.*);

`default_nettype wire
